// ===== sv/podo_pkg.sv =====
// Package with shared types, constants and the CORDIC arctangent table for the odometry block.
package podo_pkg;

  localparam int TRIG_ITERATIONS = 16;
  localparam int IterW = $clog2(TRIG_ITERATIONS + 1);
  localparam logic [31:0] DtMax = 32'd1048576;
  localparam logic [31:0] TurnPerRad = 32'd683565276;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Arctangent table in binary-angle units, indexed by CORDIC step.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    begin
      case (idx)
        5'd0: r = 32'h20000000;
        5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B;
        5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;
        5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;
        5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;
        5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;
        5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;
        5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2F9;
        5'd15: r = 32'h0000517C;
        5'd16: r = 32'h000028BE;
        5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A2F;
        5'd19: r = 32'h00000517;
        5'd20: r = 32'h0000028B;
        5'd21: r = 32'h00000145;
        5'd22: r = 32'h000000A2;
        5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_WK_HI,
    ST_WK_LO,
    ST_STEP,
    ST_CORD1,
    ST_PX_HI,
    ST_PX_LO,
    ST_POS_A,
    ST_PY_HI,
    ST_PY_LO,
    ST_HALF,
    ST_CORD2,
    ST_QUAT,
    ST_OUT
  } podo_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic acc_hi;
    logic acc_lo;
    logic sel_wk;
    logic sel_sin;
    logic step;
    logic cord_start;
    logic cord_iter;
    logic pos_a;
    logic half;
    logic quat;
  } podo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cord_done;
  } podo_sts_t;

endpackage

// ===== sv/podo_ctrl.sv =====
// Controller state machine that sequences the odometry datapath.
module podo_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  podo_pkg::podo_sts_t  sts,
  output podo_pkg::podo_cmd_t  cmd
);

  podo_pkg::podo_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= podo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      podo_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = podo_pkg::ST_MUL;
        end
      end
      podo_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = podo_pkg::ST_WK_HI;
      end
      podo_pkg::ST_WK_HI: begin
        cmd.acc_hi = 1'b1;
        cmd.sel_wk = 1'b1;
        state_nxt = podo_pkg::ST_WK_LO;
      end
      podo_pkg::ST_WK_LO: begin
        cmd.acc_lo = 1'b1;
        cmd.sel_wk = 1'b1;
        state_nxt = podo_pkg::ST_STEP;
      end
      podo_pkg::ST_STEP: begin
        cmd.step = 1'b1;
        cmd.cord_start = 1'b1;
        state_nxt = podo_pkg::ST_CORD1;
      end
      podo_pkg::ST_CORD1: begin
        cmd.cord_iter = 1'b1;
        if (sts.cord_done) begin
          state_nxt = podo_pkg::ST_PX_HI;
        end
      end
      podo_pkg::ST_PX_HI: begin
        cmd.acc_hi = 1'b1;
        state_nxt = podo_pkg::ST_PX_LO;
      end
      podo_pkg::ST_PX_LO: begin
        cmd.acc_lo = 1'b1;
        state_nxt = podo_pkg::ST_POS_A;
      end
      podo_pkg::ST_POS_A: begin
        cmd.pos_a = 1'b1;
        state_nxt = podo_pkg::ST_PY_HI;
      end
      podo_pkg::ST_PY_HI: begin
        cmd.acc_hi = 1'b1;
        cmd.sel_sin = 1'b1;
        state_nxt = podo_pkg::ST_PY_LO;
      end
      podo_pkg::ST_PY_LO: begin
        cmd.acc_lo = 1'b1;
        cmd.sel_sin = 1'b1;
        state_nxt = podo_pkg::ST_HALF;
      end
      podo_pkg::ST_HALF: begin
        cmd.half = 1'b1;
        cmd.sel_sin = 1'b1;
        cmd.cord_start = 1'b1;
        state_nxt = podo_pkg::ST_CORD2;
      end
      podo_pkg::ST_CORD2: begin
        cmd.cord_iter = 1'b1;
        if (sts.cord_done) begin
          state_nxt = podo_pkg::ST_QUAT;
        end
      end
      podo_pkg::ST_QUAT: begin
        cmd.quat = 1'b1;
        state_nxt = podo_pkg::ST_OUT;
      end
      podo_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = podo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = podo_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/podo_dp.sv =====
// Datapath: pose registers, a shared multiplier, CORDIC unit and result registers.
module podo_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  podo_pkg::podo_cmd_t        cmd,
  output podo_pkg::podo_sts_t        sts,
  input  logic                       method,
  input  logic [31:0]                in_sample_time,
  input  logic signed [23:0]         in_linear_velocity,
  input  logic signed [23:0]         in_yaw_rate,
  output logic [31:0]                out_time,
  output logic signed [31:0]         out_position_x,
  output logic signed [31:0]         out_position_y,
  output logic [31:0]                out_heading_angle,
  output logic signed [17:0]         out_orient_z,
  output logic signed [17:0]         out_orient_w,
  output logic signed [23:0]         out_echo_linear,
  output logic signed [23:0]         out_echo_yaw_rate,
  output logic                       out_method_used
);

  // Control state of the pose.
  logic [31:0] pose_x_r, pose_y_r, heading_r, prev_time_r;
  logic        seen_r;

  // Per-item registers.
  logic [20:0]        dt_r;
  logic signed [23:0] v_r, w_r;
  logic [31:0]        t_r;
  logic               meth_r;
  logic signed [44:0] d_r, wd_r;
  logic [31:0]        dth_r;
  logic               flip_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic [podo_pkg::IterW-1:0] it_r;
  logic [75:0]        acc_r;

  // Time difference with saturation; zero before the first sample.
  logic [31:0] dt_raw;
  logic [20:0] dt_sat;
  assign dt_raw = in_sample_time - prev_time_r;
  assign dt_sat = !seen_r ? 21'd0 : (dt_raw > podo_pkg::DtMax) ? 21'd1048576 : dt_raw[20:0];

  // Final CORDIC outputs after the half-turn fold.
  logic signed [33:0] cos_v, sin_v;
  assign cos_v = flip_r ? -cx_r : cx_r;
  assign sin_v = flip_r ? -cy_r : cy_r;

  // Operand magnitudes for the shared multiplier.
  logic [43:0] wd_mag;
  logic [43:0] d_mag;
  logic [33:0] c_mag;
  logic signed [33:0] trig_sel;
  assign wd_mag = wd_r[44] ? 44'(-wd_r) : wd_r[43:0];
  assign d_mag = d_r[44] ? 44'(-d_r) : d_r[43:0];
  assign trig_sel = cmd.sel_sin ? sin_v : cos_v;
  assign c_mag = trig_sel[33] ? 34'(-trig_sel) : trig_sel;

  // Shared multiplier: one 22-bit slice of a 44-bit magnitude times a 32-bit factor.
  // The upper slice goes first, the lower slice is added in the next cycle.
  logic [43:0] mul_m;
  logic [31:0] mul_c;
  logic [21:0] mul_slice;
  logic [53:0] part;
  assign mul_m = cmd.sel_wk ? wd_mag : d_mag;
  assign mul_c = cmd.sel_wk ? podo_pkg::TurnPerRad : c_mag[31:0];
  assign mul_slice = cmd.acc_hi ? mul_m[43:22] : mul_m[21:0];
  assign part = 54'(mul_slice) * 54'(mul_c);

  // Heading step: |wd| * K rounded half away from zero at shifts 32 and 33.
  logic [43:0] st_full, st_half;
  logic [31:0] dth_s, half_s;
  assign st_full = 44'((acc_r + (76'd1 << 31)) >> 32);
  assign st_half = 44'((acc_r + (76'd1 << 32)) >> 33);
  assign dth_s = wd_r[44] ? 32'(-st_full) : st_full[31:0];
  assign half_s = wd_r[44] ? 32'(-st_half) : st_half[31:0];

  // CORDIC start angle and quadrant fold.
  logic [31:0] dir;
  logic [31:0] qang;
  logic        qflip;
  always_comb begin
    if (cmd.step) begin
      dir = heading_r + (meth_r ? half_s : 32'd0);
    end else begin
      dir = {heading_r[31], heading_r[31:1]};
    end
    qflip = (dir[31:30] == 2'b01) || (dir[31:30] == 2'b10);
    qang = qflip ? (dir ^ 32'h80000000) : dir;
  end

  // One CORDIC rotation per cycle.
  logic signed [33:0] xs, ys;
  logic [31:0] at;
  assign xs = cx_r >>> it_r;
  assign ys = cy_r >>> it_r;
  assign at = podo_pkg::atan_turn(5'(it_r));
  assign sts.cord_done = (it_r == podo_pkg::IterW'(podo_pkg::TRIG_ITERATIONS));

  // Position offset: accumulated product rounded half away from zero at shift 46.
  logic [75:0] rnd;
  logic        pneg;
  logic [31:0] dpos;
  assign rnd = (acc_r + (76'd1 << 45)) >> 46;
  assign pneg = d_r[44] ^ trig_sel[33];
  assign dpos = pneg ? 32'(-rnd) : rnd[31:0];

  // Q30 to Q16 with rounding and clamp.
  function automatic logic [17:0] q16(input logic signed [33:0] v);
    logic [33:0] m;
    logic [33:0] r;
    logic [17:0] c;
    begin
      m = v[33] ? 34'(-v) : v;
      r = (m + 34'd8192) >> 14;
      c = (r > 34'd65536) ? 18'd65536 : r[17:0];
      return v[33] ? 18'(-c) : c;
    end
  endfunction

  // Pose and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r <= '0;
      pose_y_r <= '0;
      heading_r <= '0;
      prev_time_r <= '0;
      seen_r <= 1'b0;
      it_r <= '0;
    end else begin
      if (cmd.load) begin
        prev_time_r <= in_sample_time;
        seen_r <= 1'b1;
      end
      if (cmd.cord_start) begin
        it_r <= '0;
      end else if (cmd.cord_iter && !sts.cord_done) begin
        it_r <= it_r + 1'b1;
      end
      if (cmd.pos_a) begin
        pose_x_r <= pose_x_r + dpos;
        heading_r <= heading_r + dth_r;
      end
      if (cmd.half) begin
        pose_y_r <= pose_y_r + dpos;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r <= dt_sat;
      v_r <= in_linear_velocity;
      w_r <= in_yaw_rate;
      t_r <= in_sample_time;
      meth_r <= method;
    end
    if (cmd.mul) begin
      d_r <= 45'(v_r) * $signed({1'b0, dt_r});
      wd_r <= 45'(w_r) * $signed({1'b0, dt_r});
    end
    if (cmd.acc_hi) begin
      acc_r <= {part, 22'd0};
    end else if (cmd.acc_lo) begin
      acc_r <= acc_r + 76'(part);
    end
    if (cmd.step) begin
      dth_r <= dth_s;
    end
    if (cmd.cord_start) begin
      flip_r <= qflip;
      cx_r <= podo_pkg::CordicGain;
      cy_r <= '0;
      cz_r <= $signed({qang[31], qang});
    end else if (cmd.cord_iter && !sts.cord_done) begin
      if (!cz_r[32]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - $signed({1'b0, at});
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + $signed({1'b0, at});
      end
    end
    if (cmd.quat) begin
      out_orient_z <= q16(sin_v);
      out_orient_w <= q16(cos_v);
      out_time <= t_r;
      out_position_x <= pose_x_r;
      out_position_y <= pose_y_r;
      out_heading_angle <= heading_r;
      out_echo_linear <= v_r;
      out_echo_yaw_rate <= w_r;
      out_method_used <= meth_r;
    end
  end

endmodule

// ===== sv/planar_odometry_integrator.sv =====
// Top level of the planar odometry integrator.
// Each accepted velocity sample passes through both CORDIC runs and all multiplier passes
// before its result is offered; the block is idle again in the cycle after the result transfer,
// and a new sample is not taken before the previous result has been transferred.
// The work is done by the single CORDIC unit, which rotates once per cycle and is used twice
// per sample (travel direction and half-heading quaternion), and by one shared 22 by 32 bit
// multiplier that forms each wide product (heading step, x offset, y offset) in two passes.
// One sample is processed at a time; the method register may be written while idle.
module planar_odometry_integrator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_sample_time,
  input  logic signed [23:0] in_linear_velocity,
  input  logic signed [23:0] in_yaw_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_time,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic [31:0]        out_heading_angle,
  output logic signed [17:0] out_orient_z,
  output logic signed [17:0] out_orient_w,
  output logic signed [23:0] out_echo_linear,
  output logic signed [23:0] out_echo_yaw_rate,
  output logic               out_method_used,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  podo_pkg::podo_cmd_t cmd;
  podo_pkg::podo_sts_t sts;
  logic method_r;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= 1'b0;
    end else if (cfg_valid) begin
      method_r <= cfg_data;
    end
  end

  podo_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  podo_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .method(method_r),
    .in_sample_time(in_sample_time), .in_linear_velocity(in_linear_velocity),
    .in_yaw_rate(in_yaw_rate), .out_time(out_time), .out_position_x(out_position_x),
    .out_position_y(out_position_y), .out_heading_angle(out_heading_angle),
    .out_orient_z(out_orient_z), .out_orient_w(out_orient_w),
    .out_echo_linear(out_echo_linear), .out_echo_yaw_rate(out_echo_yaw_rate),
    .out_method_used(out_method_used)
  );

  // Input is never accepted while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted while result pending");

  // A transfer of an input leads to busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after transfer");

  // A stalled result stays offered, and its time, x position and w orientation stay unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_time) &&
      $stable(out_position_x) && $stable(out_orient_w))) else $error("stalled result changed");

endmodule

// ===== dv/podo_checker.sv =====
// Checker for the odometry block: predicts each pose from the accepted samples and compares.
module podo_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        in_sample_time,
  input  logic signed [23:0] in_linear_velocity,
  input  logic signed [23:0] in_yaw_rate,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [31:0]        out_time,
  input  logic signed [31:0] out_position_x,
  input  logic signed [31:0] out_position_y,
  input  logic [31:0]        out_heading_angle,
  input  logic signed [17:0] out_orient_z,
  input  logic signed [17:0] out_orient_w,
  input  logic signed [23:0] out_echo_linear,
  input  logic signed [23:0] out_echo_yaw_rate,
  input  logic               out_method_used,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  output int                 fail_count,
  output int                 pending_poses
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] stamp;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] heading;
    logic [17:0] qz;
    logic [17:0] qw;
    logic [23:0] lin;
    logic [23:0] yaw;
    logic        method;
  } pose_t;

  pose_t       pose_queue[$];
  logic        use_midpoint;
  logic [31:0] track_x, track_y, track_heading, last_stamp;
  logic        have_stamp;

  // Product of a signed value and a signed factor, scaled down by 2^s,
  // rounded half away from zero.
  function automatic longint scale_round(longint p, longint c, int s);
    logic [127:0] mp, mc, r;
    logic         neg;
    neg = (p < 0) != (c < 0);
    mp = 128'(p < 0 ? -p : p);
    mc = 128'(c < 0 ? -c : c);
    r = (mp * mc + (128'd1 << (s - 1))) >> s;
    return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  // Rotation-mode CORDIC over a binary angle; results in Q30.
  task automatic rotate(input logic [31:0] ang, output longint cs, output longint sn);
    logic   flip;
    longint x, y, z, xs, ys;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) begin
      ang = ang ^ 32'h80000000;
    end
    x = podo_pkg::CordicGain;
    y = 0;
    z = longint'(signed'(ang));
    for (int i = 0; i < podo_pkg::TRIG_ITERATIONS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(podo_pkg::atan_turn(5'(i)));
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(podo_pkg::atan_turn(5'(i)));
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  // Q30 to Q16 with rounding and clamping to one.
  function automatic logic [17:0] to_q16(longint v);
    longint m, r;
    m = v < 0 ? -v : v;
    r = (m + 8192) >>> 14;
    if (r > 65536) begin
      r = 65536;
    end
    return 18'(v < 0 ? -r : r);
  endfunction

  // Advance the tracked pose by one velocity sample.
  task automatic integrate(input logic [31:0] t, input logic signed [23:0] v,
                           input logic signed [23:0] w, output pose_t p);
    logic [31:0] dt, dir, half;
    longint      travel, turn, c, s, cq, sq;
    dt = '0;
    if (have_stamp) begin
      dt = t - last_stamp;
      if (dt > podo_pkg::DtMax) begin
        dt = podo_pkg::DtMax;
      end
    end
    have_stamp = 1'b1;
    last_stamp = t;
    travel = longint'(v) * longint'({1'b0, dt});
    turn = longint'(w) * longint'({1'b0, dt});
    dir = track_heading;
    if (use_midpoint) begin
      dir = dir + 32'(scale_round(turn, longint'(podo_pkg::TurnPerRad), 33));
    end
    rotate(dir, c, s);
    track_x = track_x + 32'(scale_round(travel, c, 46));
    track_y = track_y + 32'(scale_round(travel, s, 46));
    track_heading = track_heading + 32'(scale_round(turn, longint'(podo_pkg::TurnPerRad), 32));
    half = {track_heading[31], track_heading[31:1]};
    rotate(half, cq, sq);
    p.stamp = t;
    p.px = track_x;
    p.py = track_y;
    p.heading = track_heading;
    p.qz = to_q16(sq);
    p.qw = to_q16(cq);
    p.lin = v;
    p.yaw = w;
    p.method = use_midpoint;
  endtask

  // Track config writes, predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    pose_t p, e;
    if (!rst_n) begin
      use_midpoint <= 1'b0;
      track_x = '0;
      track_y = '0;
      track_heading = '0;
      last_stamp = '0;
      have_stamp = 1'b0;
      fail_count = 0;
      pose_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pose_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected pose transfer: time %h", out_time);
          end
        end else begin
          e = pose_queue.pop_front();
          if (out_time !== e.stamp || out_position_x !== e.px || out_position_y !== e.py ||
              out_heading_angle !== e.heading || out_orient_z !== e.qz ||
              out_orient_w !== e.qw || out_echo_linear !== e.lin ||
              out_echo_yaw_rate !== e.yaw || out_method_used !== e.method) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("pose mismatch: exp t=%h x=%h y=%h h=%h z=%h w=%h v=%h r=%h m=%b",
                       e.stamp, e.px, e.py, e.heading, e.qz, e.qw, e.lin, e.yaw, e.method);
              $display("               got t=%h x=%h y=%h h=%h z=%h w=%h v=%h r=%h m=%b",
                       out_time, out_position_x, out_position_y, out_heading_angle,
                       out_orient_z, out_orient_w, out_echo_linear, out_echo_yaw_rate,
                       out_method_used);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        integrate(in_sample_time, in_linear_velocity, in_yaw_rate, p);
        pose_queue.push_back(p);
      end
      if (cfg_valid && cfg_ready) begin
        use_midpoint <= cfg_data;
      end
    end
    pending_poses = pose_queue.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the odometry testbench: clock, reset, stimulus, receiver stalls and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [31:0]        in_sample_time;
  logic signed [23:0] in_linear_velocity;
  logic signed [23:0] in_yaw_rate;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        out_time;
  logic signed [31:0] out_position_x;
  logic signed [31:0] out_position_y;
  logic [31:0]        out_heading_angle;
  logic signed [17:0] out_orient_z;
  logic signed [17:0] out_orient_w;
  logic signed [23:0] out_echo_linear;
  logic signed [23:0] out_echo_yaw_rate;
  logic               out_method_used;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;
  int                 fail_count;
  int                 pending_poses;
  logic               sample_taken;
  logic               method_taken;
  logic               long_hold;
  logic [31:0]        clock_now;
  int                 cycle_count = 0;

  planar_odometry_integrator u_top (.*);

  podo_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Transfer flags, sampled on the edge that completes the handshake.
  always @(posedge clk) begin
    sample_taken <= in_valid && !in_stall;
    method_taken <= cfg_valid && cfg_ready;
  end

  // Receiver stalls: a mode that changes every so often, overridden by the long hold.
  always @(negedge clk) begin
    int mode;
    if (cycle_count % 97 == 0) begin
      mode = $urandom_range(0, 3);
    end
    case (mode)
      0: out_stall <= long_hold;
      1: out_stall <= long_hold || ($urandom_range(0, 3) == 0);
      2: out_stall <= long_hold || ($urandom_range(0, 3) != 0);
      default: out_stall <= long_hold || (((cycle_count / 5) % 2) == 1);
    endcase
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Present one sample and hold it until it is taken.
  task automatic send_sample(input logic [31:0] t, input logic [23:0] v, input logic [23:0] w);
    in_valid = 1'b1;
    in_sample_time = t;
    in_linear_velocity = v;
    in_yaw_rate = w;
    @(negedge clk);
    while (!sample_taken) begin
      @(negedge clk);
    end
  endtask

  // Drop valid for a random gap after a burst.
  task automatic maybe_gap(input int burst_left);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 60)) @(negedge clk);
    end
  endtask

  // Wait until every expected pose has come and the block is idle, then write the method.
  task automatic write_method(input logic m);
    in_valid = 1'b0;
    @(negedge clk);
    while (pending_poses != 0) begin
      @(negedge clk);
    end
    repeat (50) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = m;
    @(negedge clk);
    while (!method_taken) begin
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  function automatic logic [23:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom);
      default: return 24'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  // Next timestamp: mostly small steps, sometimes gaps, reversals or wraps.
  function automatic logic [31:0] next_stamp(input logic [31:0] t);
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return t - $urandom_range(1, 5000);
      2: return t + $urandom_range(1048577, 3000000);
      3: return t + 32'd1048576;
      default: return t + $urandom_range(0, 6000);
    endcase
  endfunction

  // Long receiver hold-off while the sender keeps offering samples.
  initial begin
    long_hold = 1'b0;
    wait (cycle_count == 20000);
    @(negedge clk);
    long_hold = 1'b1;
    repeat (400) @(negedge clk);
    long_hold = 1'b0;
  end

  initial begin
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_time = '0;
    in_linear_velocity = '0;
    in_yaw_rate = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: first sample, field extremes, backward time, wrap and saturated gaps.
    send_sample(32'hFFFF_FF00, 24'h7FFFFF, 24'h800000);
    send_sample(32'h0000_0100, 24'h7FFFFF, 24'h000000);
    send_sample(32'h0000_0000, 24'h800000, 24'h7FFFFF);
    send_sample(32'h0010_0000, 24'h000000, 24'h000000);
    send_sample(32'hFFFF_FFFF, 24'hFFFFFF, 24'h000001);
    send_sample(32'h0000_1000, 24'h000000, 24'h7FFFFF);
    for (int i = 0; i < 10; i++) begin
      clock_now = 32'h4000_0000 + i * 32'h0020_0000;
      send_sample(clock_now, 24'h7FFFFF, 24'h000100);
    end
    write_method(1'b1);
    send_sample(clock_now + 32'h0010_0000, 24'h7FFFFF, 24'h7FFFFF);
    send_sample(clock_now + 32'h0020_0000, 24'h800000, 24'h800000);
    send_sample(clock_now + 32'h0020_0400, 24'h123456, 24'h654321);
    clock_now = clock_now + 32'h0020_0400;

    // Random phases across both methods.
    for (int phase = 0; phase < 4; phase++) begin
      write_method(phase[0]);
      burst = $urandom_range(1, 30);
      for (int i = 0; i < 200; i++) begin
        clock_now = next_stamp(clock_now);
        send_sample(clock_now, pick_rate(), pick_rate());
        burst--;
        maybe_gap(burst);
        if (burst == 0) begin
          burst = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 30);
        end
      end
    end
    in_valid = 1'b0;

    while (pending_poses != 0) begin
      @(negedge clk);
    end
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
